[hdl/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[hdl/cbba_pkg.sv]
// Types, constants and control store of the chained block bump allocator.
`timescale 1ns / 1ps
package cbba_pkg;

    // Field and register widths
    localparam int CFG_W  = 17;
    localparam int SIZE_W = 17;
    localparam int FAIL_W = 3;

    // Register reset values
    localparam logic [CFG_W-1:0] BLOCK_BYTES_RST     = 17'd4096;
    localparam logic [CFG_W-1:0] MAX_SMALL_BYTES_RST = 17'd4032;

    // Fail count thresholds
    localparam logic [FAIL_W-1:0] FAIL_SKIP = 3'd4;
    localparam logic [FAIL_W-1:0] FAIL_MAX  = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_ALLOC    = 2'd0;
    localparam logic [1:0] ST_LARGE    = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK = 2'd2;
    localparam logic [1:0] ST_RST_DONE = 2'd3;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // Register indexes
    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic REG_MAX_SMALL   = 1'b1;

    // Sequencer step addresses
    typedef logic [3:0] step_t;
    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_DISPATCH = 4'd1;
    localparam step_t S_LIMIT    = 4'd2;
    localparam step_t S_RD       = 4'd3;
    localparam step_t S_TEST     = 4'd4;
    localparam step_t S_ADV      = 4'd5;
    localparam step_t S_FULLCHK  = 4'd6;
    localparam step_t S_WRD      = 4'd7;
    localparam step_t S_WUPD     = 4'd8;
    localparam step_t S_OPEN     = 4'd9;
    localparam step_t S_BUMP     = 4'd10;
    localparam step_t S_POOLRST  = 4'd11;
    localparam step_t S_LARGE    = 4'd12;
    localparam step_t S_FULL     = 4'd13;
    localparam step_t S_EMIT     = 4'd14;

    // Datapath actions
    typedef enum logic [3:0] {
        A_NONE,
        A_LATCH,
        A_LOAD_PTR,
        A_READ,
        A_INC_PTR,
        A_FAIL_UPD,
        A_OPEN,
        A_BUMP,
        A_POOL_RST,
        A_SET_LARGE,
        A_SET_FULL,
        A_EMIT
    } act_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_IN,
        C_CMD_RST,
        C_TOO_LARGE,
        C_FITS,
        C_MORE,
        C_POOL_FULL,
        C_OUT_BUSY
    } cond_t;

    // One control word: action, condition, target when true, target when false
    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jmp_t;
        step_t jmp_f;
    } ctrl_word_t;

    // Control store
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t cw;
        cw = '{A_NONE, C_ALWAYS, S_IDLE, S_IDLE};
        unique case (step)
            S_IDLE:     cw = '{A_LATCH,     C_NO_IN,     S_IDLE,    S_DISPATCH};
            S_DISPATCH: cw = '{A_NONE,      C_CMD_RST,   S_POOLRST, S_LIMIT};
            S_LIMIT:    cw = '{A_LOAD_PTR,  C_TOO_LARGE, S_LARGE,   S_RD};
            S_RD:       cw = '{A_READ,      C_ALWAYS,    S_TEST,    S_TEST};
            S_TEST:     cw = '{A_NONE,      C_FITS,      S_BUMP,    S_ADV};
            S_ADV:      cw = '{A_INC_PTR,   C_MORE,      S_RD,      S_FULLCHK};
            S_FULLCHK:  cw = '{A_LOAD_PTR,  C_POOL_FULL, S_FULL,    S_WRD};
            S_WRD:      cw = '{A_READ,      C_MORE,      S_WUPD,    S_OPEN};
            S_WUPD:     cw = '{A_FAIL_UPD,  C_ALWAYS,    S_WRD,     S_WRD};
            S_OPEN:     cw = '{A_OPEN,      C_ALWAYS,    S_EMIT,    S_EMIT};
            S_BUMP:     cw = '{A_BUMP,      C_ALWAYS,    S_EMIT,    S_EMIT};
            S_POOLRST:  cw = '{A_POOL_RST,  C_ALWAYS,    S_EMIT,    S_EMIT};
            S_LARGE:    cw = '{A_SET_LARGE, C_ALWAYS,    S_EMIT,    S_EMIT};
            S_FULL:     cw = '{A_SET_FULL,  C_ALWAYS,    S_EMIT,    S_EMIT};
            S_EMIT:     cw = '{A_EMIT,      C_OUT_BUSY,  S_EMIT,    S_IDLE};
            default:    cw = '{A_NONE,      C_ALWAYS,    S_IDLE,    S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

[hdl/chained_block_bump_allocator_unit.sv]
// Chained block bump allocator: microcoded sequencer, block tables and APB registers.
//
// Usage:
// - Request channel (in_valid/in_ready): cmd selects allocate or pool reset,
//   req_bytes gives the size. One item is in work at a time; in_ready is high
//   only while the sequencer waits at its idle step.
// - Result channel (out_valid/out_ready): status, block_index, byte_offset,
//   held in an output register. The next item is taken while a result waits;
//   its own result waits at the emit step until the register is free.
// - APB port: block_bytes at 0x0, max_small_bytes at 0x4; write only when idle.
// Steps from accept to the emit step:
// - pool reset: dispatch, pool reset; too large: dispatch, limit, large
// - hit: dispatch, limit, read/test/advance per missed block, read and test, bump
// - new block opened: search misses, full check, fail count walk, open
// Each searched block costs a read step, a test step and an advance step, set
// by the registered read of the block tables; the fail count walk costs a read
// and a write step per block it updates. Each item ends back at the idle step.
// Reset (rst_n low) restores the registers, rewinds every block and leaves one
// block open. A stalled receiver holds the result; nothing is dropped.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chained_block_bump_allocator_unit #(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [16:0] req_bytes,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  block_index,
    output logic [15:0] byte_offset
);
    import cbba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CFG_W-1:0] HDR = CFG_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

    // Configuration registers
    logic [CFG_W-1:0] block_bytes_reg;
    logic [CFG_W-1:0] max_small_reg;

    // Sequencer and pool state
    step_t            step_reg;
    step_t            step_next;
    ctrl_word_t       cw;
    logic             cond_true;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_inc;
    logic [IDX_W-1:0] ptr_idx;
    logic [IDX_W-1:0] current_reg;
    logic [CNT_W-1:0] open_reg;
    logic [IDX_W-1:0] open_idx;
    logic             fill_vld_reg [MAX_BLOCKS];
    logic             fail_vld_reg [MAX_BLOCKS];

    // Block tables
    logic [CFG_W-1:0]  fill_mem [MAX_BLOCKS];
    logic [FAIL_W-1:0] fail_mem [MAX_BLOCKS];
    logic [CFG_W-1:0]  rd_fill_reg;
    logic [FAIL_W-1:0] rd_fail_reg;
    logic              rd_fill_vld_reg;
    logic              rd_fail_vld_reg;

    // Item and result holding
    logic              cmd_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [1:0]        res_status_reg;
    logic [3:0]        res_block_reg;
    logic [15:0]       res_offset_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [3:0]        block_index_reg;
    logic [15:0]       byte_offset_reg;

    // Datapath signals
    logic              in_acc;
    logic              out_busy;
    logic              cfg_wr;
    logic [CFG_W-1:0]  room_cfg;
    logic [CFG_W-1:0]  small_limit;
    logic              too_large;
    logic [CFG_W-1:0]  fill_eff;
    logic              fits;
    logic [FAIL_W-1:0] fail_old;
    logic [FAIL_W-1:0] fail_new;
    logic              fill_we;
    logic [IDX_W-1:0]  fill_wa;
    logic [CFG_W-1:0]  fill_wd;

    assign pready    = 1'b1;
    assign in_ready  = (step_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_busy  = out_valid_reg && !out_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign block_index = block_index_reg;
    assign byte_offset = byte_offset_reg;

    assign ptr_idx  = ptr_reg[IDX_W-1:0];
    assign ptr_inc  = ptr_reg + 1'b1;
    assign open_idx = open_reg[IDX_W-1:0];

    // Register read back
    always_comb
    begin
        prdata = (paddr[2] == REG_MAX_SMALL) ? 32'(max_small_reg) : 32'(block_bytes_reg);
    end

    // Small request limit: min(max_small_bytes, block_bytes - header), 0 if no room
    always_comb
    begin
        room_cfg    = block_bytes_reg - HDR;
        small_limit = (block_bytes_reg < HDR) ? '0 :
                      ((max_small_reg < room_cfg) ? max_small_reg : room_cfg);
        too_large   = (size_reg > small_limit);
    end

    // Room test on the block just read; a block filled past its end fits only a zero-byte request
    always_comb
    begin
        fill_eff = rd_fill_vld_reg ? rd_fill_reg : HDR;
        if (fill_eff <= block_bytes_reg)
        begin
            fits = ((block_bytes_reg - fill_eff) >= size_reg);
        end
        else
        begin
            fits = (size_reg == '0);
        end
        fail_old = rd_fail_vld_reg ? rd_fail_reg : '0;
        fail_new = (fail_old < FAIL_MAX) ? (fail_old + 1'b1) : fail_old;
    end

    // Control word fetch and jump
    always_comb
    begin
        cw = ucode(step_reg);
        case (cw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_IN:     cond_true = !in_valid;
            C_CMD_RST:   cond_true = (cmd_reg == CMD_RESET);
            C_TOO_LARGE: cond_true = too_large;
            C_FITS:      cond_true = fits;
            C_MORE:      cond_true = (ptr_inc < open_reg);
            C_POOL_FULL: cond_true = (open_reg >= MAX_CNT);
            C_OUT_BUSY:  cond_true = out_busy;
            default:     cond_true = 1'b1;
        endcase
        step_next = cond_true ? cw.jmp_t : cw.jmp_f;
    end

    // Fill table write port
    always_comb
    begin
        fill_we = 1'b0;
        fill_wa = ptr_idx;
        fill_wd = fill_eff + size_reg;
        case (cw.act)
            A_BUMP:
            begin
                fill_we = 1'b1;
            end
            A_OPEN:
            begin
                fill_we = 1'b1;
                fill_wa = open_idx;
                fill_wd = HDR + size_reg;
            end
            default:
            begin
                fill_we = 1'b0;
            end
        endcase
    end

    // Block tables, registered read at the pointer
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_wa] <= fill_wd;
        end
        if (cw.act == A_FAIL_UPD)
        begin
            fail_mem[ptr_idx] <= fail_new;
        end
        if (cw.act == A_READ)
        begin
            rd_fill_reg     <= fill_mem[ptr_idx];
            rd_fail_reg     <= fail_mem[ptr_idx];
            rd_fill_vld_reg <= fill_vld_reg[ptr_idx];
            rd_fail_vld_reg <= fail_vld_reg[ptr_idx];
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (cw.act == A_LATCH && in_acc)
        begin
            cmd_reg  <= cmd;
            size_reg <= req_bytes;
        end
        case (cw.act)
            A_BUMP:
            begin
                res_status_reg <= ST_ALLOC;
                res_block_reg  <= 4'(ptr_reg);
                res_offset_reg <= 16'(fill_eff);
            end
            A_OPEN:
            begin
                res_status_reg <= ST_ALLOC;
                res_block_reg  <= 4'(open_reg);
                res_offset_reg <= 16'(HDR);
            end
            A_POOL_RST:
            begin
                res_status_reg <= ST_RST_DONE;
                res_block_reg  <= '0;
                res_offset_reg <= '0;
            end
            A_SET_LARGE:
            begin
                res_status_reg <= ST_LARGE;
                res_block_reg  <= '0;
                res_offset_reg <= '0;
            end
            A_SET_FULL:
            begin
                res_status_reg <= ST_NO_BLOCK;
                res_block_reg  <= '0;
                res_offset_reg <= '0;
            end
            default:
            begin
            end
        endcase
        if (cw.act == A_EMIT && !out_busy)
        begin
            status_reg      <= res_status_reg;
            block_index_reg <= res_block_reg;
            byte_offset_reg <= res_offset_reg;
        end
    end

    // Control state: sequencer, pointers, valid bits, output flag, registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= S_IDLE;
            ptr_reg         <= '0;
            current_reg     <= '0;
            open_reg        <= CNT_W'(1);
            out_valid_reg   <= 1'b0;
            block_bytes_reg <= BLOCK_BYTES_RST;
            max_small_reg   <= MAX_SMALL_BYTES_RST;
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                fill_vld_reg[i] <= 1'b0;
                fail_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            step_reg <= step_next;

            // Register writes
            if (cfg_wr)
            begin
                if (paddr[2] == REG_BLOCK_BYTES)
                begin
                    block_bytes_reg <= pwdata[CFG_W-1:0];
                end
                else
                begin
                    max_small_reg <= pwdata[CFG_W-1:0];
                end
            end

            // Output register handshake
            if (cw.act == A_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cw.act)
                A_LOAD_PTR:
                begin
                    ptr_reg <= CNT_W'(current_reg);
                end
                A_INC_PTR:
                begin
                    ptr_reg <= ptr_inc;
                end
                A_FAIL_UPD:
                begin
                    fail_vld_reg[ptr_idx] <= 1'b1;
                    if (fail_old > FAIL_SKIP)
                    begin
                        current_reg <= IDX_W'(ptr_inc);
                    end
                    ptr_reg <= ptr_inc;
                end
                A_BUMP:
                begin
                    fill_vld_reg[ptr_idx] <= 1'b1;
                end
                A_OPEN:
                begin
                    fill_vld_reg[open_idx] <= 1'b1;
                    fail_vld_reg[open_idx] <= 1'b0;
                    open_reg <= open_reg + 1'b1;
                end
                A_POOL_RST:
                begin
                    current_reg <= '0;
                    for (int i = 0; i < MAX_BLOCKS; i++)
                    begin
                        fill_vld_reg[i] <= 1'b0;
                        fail_vld_reg[i] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Checks on sequencer and pool state
    `ASSERT_AT(a_cur_in_pool, clk, rst_n, (CNT_W'(current_reg) < open_reg), "current block past open blocks")
    `ASSERT_AT(a_accept_dispatch, clk, rst_n, (in_valid && in_ready) |=> (step_reg == S_DISPATCH), "accepted item not dispatched")
    `ASSERT_AT(a_open_grows, clk, rst_n, (step_reg == S_OPEN) |=> (open_reg == $past(open_reg) + 1'b1), "open count did not advance")
    `ASSERT_NEVER(a_full_only_at_limit, clk, rst_n, (step_reg == S_FULL) && (open_reg != MAX_CNT), "out of blocks below limit")

endmodule
